// ===== rtl/ibsc_pkg.sv =====
`timescale 1ns / 1ps

package ibsc_pkg;

    // Fixed field widths and fixed-point format
    localparam int SAMPLE_BITS     = 16;
    localparam int FRAC_BITS       = 14;
    localparam int COUNT_BITS      = 16;
    localparam int AXES            = 3;
    localparam int SENSORS         = 3;
    localparam int SLOTS_PER_SENSOR = 12;
    localparam int COEF_SLOTS      = SENSORS * SLOTS_PER_SENSOR;
    localparam int SLOT_W          = 6;
    localparam int GYRO_SENSOR     = 1;

    // Derived datapath widths
    localparam int SUM_W     = SAMPLE_BITS + 1;
    localparam int PROD_W    = SAMPLE_BITS + SUM_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int QUO_W     = SUM_W;
    localparam int NEWB_W    = SAMPLE_BITS + 3;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]       t_sum;

    localparam t_sample COEF_ONE = t_sample'(1 << FRAC_BITS);
    localparam logic [SLOT_W-1:0] GYRO_BASE = SLOT_W'(GYRO_SENSOR * SLOTS_PER_SENSOR);
    localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // Command codes of an input item
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_WRITE  = 2'd3;

    // Coefficient write sources
    localparam logic [1:0] WR_COEF = 2'd0;
    localparam logic [1:0] WR_NEG  = 2'd1;
    localparam logic [1:0] WR_BIAS = 2'd2;

    typedef struct packed {
        logic              en;
        logic              est;
        logic              bias;
        logic [1:0]        sens;
        logic [1:0]        row;
        logic [1:0]        col;
        logic [SLOT_W-1:0] addr;
    } t_rd_cmd;

    typedef struct packed {
        logic       load_in;
        logic       clr_run;
        logic       start_est;
        logic       inc_count;
        logic       upd_last;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic [1:0] wr_axis;
        t_rd_cmd    rd;
        logic       div_go;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_ok;
        logic       running;
        logic       div_busy;
    } t_dp_status;

    // Saturate a wide signed value to the sample range
    function automatic t_sample sat_sample(input logic signed [ACC_W-1:0] v);
        t_sample res;
        if (v > SAT_HI) begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/ibsc_div.sv =====
`timescale 1ns / 1ps

module ibsc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ibsc_pkg::QUO_W-1:0]       i_num,
    input  logic [ibsc_pkg::COUNT_BITS-1:0]  i_den,
    output logic                             o_busy,
    output logic [ibsc_pkg::QUO_W-1:0]       o_quo
);
    import ibsc_pkg::*;

    logic                   r_busy;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [COUNT_BITS-1:0]  r_rem;
    logic [COUNT_BITS-1:0]  r_den;
    logic [QUO_W-1:0]       r_quo;
    logic [COUNT_BITS:0]    trial;
    logic [COUNT_BITS:0]    diff;
    logic                   ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/ibsc_dp.sv =====
`timescale 1ns / 1ps

module ibsc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ibsc_pkg::t_dp_cmd                 i_cmd,
    output ibsc_pkg::t_dp_status              o_status,
    input  logic [1:0]                        i_command,
    input  ibsc_pkg::t_sample                 i_raw [ibsc_pkg::SENSORS][ibsc_pkg::AXES],
    input  logic [ibsc_pkg::SLOT_W-1:0]       i_coef_index,
    input  ibsc_pkg::t_sample                 i_coef_value,
    output ibsc_pkg::t_sample                 o_res [ibsc_pkg::SENSORS][ibsc_pkg::AXES],
    output logic                              o_estimating,
    output logic [ibsc_pkg::COUNT_BITS-1:0]   o_samples_averaged
);
    import ibsc_pkg::*;

    // Latched input item
    logic [1:0]         r_cmd;
    t_sample            r_raw [SENSORS][AXES];
    logic [SLOT_W-1:0]  r_cidx;
    t_sample            r_cval;

    // Estimator state
    logic                   r_running;
    logic [COUNT_BITS-1:0]  r_count;
    t_sample                r_last [AXES];

    // Coefficient store
    t_sample                mem [COEF_SLOTS];
    logic [COEF_SLOTS-1:0]  r_vld;
    logic [SLOT_W-1:0]      wa;
    t_sample                wd;
    t_sample                r_rd_data;
    logic                   r_rd_vld;
    logic                   r_rd_diag;
    t_sample                eff;

    // Stream pipeline
    t_rd_cmd                    r_s1;
    t_rd_cmd                    r_s2;
    t_rd_cmd                    s2_next;
    t_sum                       r_v [AXES];
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    acc_next;
    t_sample                    r_res [SENSORS][AXES];

    // Bias update
    t_sample                    r_bold [AXES];
    logic [AXES-1:0]            r_qneg;
    t_sum                       dvd [AXES];
    logic [QUO_W-1:0]           mag [AXES];
    logic [QUO_W-1:0]           quo [AXES];
    logic [AXES-1:0]            busy;
    logic signed [NEWB_W-1:0]   qs [AXES];
    logic signed [NEWB_W-1:0]   newb [AXES];
    t_sum                       neg_last;

    // Output register
    t_sample                r_out [SENSORS][AXES];
    logic                   r_out_est;
    logic [COUNT_BITS-1:0]  r_out_cnt;

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_command;
            r_raw  <= i_raw;
            r_cidx <= i_coef_index;
            r_cval <= i_coef_value;
        end
    end

    // Track estimation run state, sample count and latest raw gyro
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_count   <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_last[a] <= '0;
            end
        end else begin
            if (i_cmd.clr_run) begin
                r_running <= 1'b0;
            end
            if (i_cmd.start_est) begin
                r_running <= 1'b1;
                r_count   <= '0;
            end
            if (i_cmd.inc_count && r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.upd_last) begin
                r_last <= r_raw[GYRO_SENSOR];
            end
        end
    end

    // Select write address and data
    assign neg_last = -(SUM_W'(r_last[i_cmd.wr_axis]));

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_NEG: begin
                wa = GYRO_BASE + SLOT_W'(i_cmd.wr_axis);
                wd = sat_sample(ACC_W'(neg_last));
            end
            WR_BIAS: begin
                wa = GYRO_BASE + SLOT_W'(i_cmd.wr_axis);
                wd = sat_sample(ACC_W'(newb[i_cmd.wr_axis]));
            end
            default: begin
                wa = r_cidx;
                wd = r_cval;
            end
        endcase
    end

    // Coefficient memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wa] <= wd;
        end
        if (i_cmd.rd.en) begin
            r_rd_data <= mem[i_cmd.rd.addr];
        end
    end

    // Written flags; an unwritten slot reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd.en) begin
            r_rd_vld  <= r_vld[i_cmd.rd.addr];
            r_rd_diag <= i_cmd.rd.addr[1:0] == 2'b11;
        end
    end

    assign eff = r_rd_vld ? r_rd_data : (r_rd_diag ? COEF_ONE : '0);

    // Forward only matrix steps to the accumulator
    always_comb begin
        s2_next    = r_s1;
        s2_next.en = r_s1.en && !r_s1.bias && !r_s1.est;
    end

    // Pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_cmd.rd;
            r_s2 <= s2_next;
        end
    end

    // Read stage: add bias, multiply by scale entry, or hold old gyro bias
    always_ff @(posedge i_clk) begin
        if (r_s1.en) begin
            if (r_s1.est) begin
                r_bold[r_s1.col] <= eff;
            end else if (r_s1.bias) begin
                r_v[r_s1.col] <= SUM_W'(r_raw[r_s1.sens][r_s1.col]) + SUM_W'(eff);
            end else begin
                r_prod <= eff * r_v[r_s1.col];
            end
        end
    end

    // Accumulate one row, then floor, saturate and hold the axis result
    assign acc_next = (r_s2.col == 2'd0 ? '0 : r_acc) + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_s2.en) begin
            r_acc <= acc_next;
            if (r_s2.col == AXIS_LAST) begin
                r_res[r_s2.sens][r_s2.row] <= sat_sample(acc_next >>> FRAC_BITS);
            end
        end
    end

    // Gyro bias update: one divider lane per axis
    for (genvar g = 0; g < AXES; g++) begin : g_lane
        assign dvd[g] = SUM_W'(r_bold[g]) + SUM_W'(r_raw[GYRO_SENSOR][g]);
        assign mag[g] = dvd[g][SUM_W-1] ? QUO_W'(-dvd[g]) : QUO_W'(dvd[g]);

        ibsc_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_cmd.div_go),
            .i_num   (mag[g]),
            .i_den   (r_count),
            .o_busy  (busy[g]),
            .o_quo   (quo[g])
        );

        assign qs[g]   = r_qneg[g] ? -$signed(NEWB_W'(quo[g])) : $signed(NEWB_W'(quo[g]));
        assign newb[g] = NEWB_W'(r_bold[g]) - qs[g];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            for (int a = 0; a < AXES; a++) begin
                r_qneg[a] <= dvd[a][SUM_W-1];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out     <= r_res;
            r_out_est <= r_running;
            r_out_cnt <= r_count;
        end
    end

    assign o_res              = r_out;
    assign o_estimating       = r_out_est;
    assign o_samples_averaged = r_out_cnt;

    assign o_status.cmd      = r_cmd;
    assign o_status.idx_ok   = r_cidx < SLOT_W'(COEF_SLOTS);
    assign o_status.running  = r_running;
    assign o_status.div_busy = |busy;

endmodule

// ===== rtl/ibsc_ctrl.sv =====
`timescale 1ns / 1ps

module ibsc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ibsc_pkg::t_dp_cmd     o_cmd,
    input  ibsc_pkg::t_dp_status  i_status
);
    import ibsc_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_START_WR = 4'd2;
    localparam logic [3:0] S_EST_RD   = 4'd3;
    localparam logic [3:0] S_EST_WAIT = 4'd4;
    localparam logic [3:0] S_DIV_GO   = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_EST_WB   = 4'd7;
    localparam logic [3:0] S_STREAM   = 4'd8;
    localparam logic [3:0] S_DRAIN    = 4'd9;
    localparam logic [3:0] S_PUBLISH  = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_sens, n_sens;
    logic [1:0] r_row, n_row;
    logic [1:0] r_col, n_col;
    logic       r_bias_ph, n_bias_ph;
    logic       r_drain, n_drain;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic [SLOT_W-1:0] stream_addr;

    assign out_free = !r_out_valid || !i_out_stall;

    // Slot address of the current stream step: sensor*12 + bias or matrix offset
    always_comb begin
        stream_addr = SLOT_W'({r_sens, 3'b000}) + SLOT_W'({r_sens, 2'b00});
        if (r_bias_ph) begin
            stream_addr = stream_addr + SLOT_W'(r_col);
        end else begin
            stream_addr = stream_addr + SLOT_W'(AXES) + SLOT_W'({r_row, 1'b0})
                        + SLOT_W'(r_row) + SLOT_W'(r_col);
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_sens      = r_sens;
        n_row       = r_row;
        n_col       = r_col;
        n_bias_ph   = r_bias_ph;
        n_drain     = r_drain;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.cmd)
                    CMD_STOP: begin
                        o_cmd.clr_run = 1'b1;
                        n_state       = S_IDLE;
                    end
                    CMD_WRITE: begin
                        o_cmd.wr_en  = i_status.idx_ok;
                        o_cmd.wr_sel = WR_COEF;
                        n_state      = S_IDLE;
                    end
                    CMD_START: begin
                        o_cmd.start_est = 1'b1;
                        n_axis          = '0;
                        n_state         = S_START_WR;
                    end
                    default: begin
                        o_cmd.upd_last = 1'b1;
                        if (i_status.running) begin
                            o_cmd.inc_count = 1'b1;
                            n_axis          = '0;
                            n_state         = S_EST_RD;
                        end else begin
                            n_sens    = '0;
                            n_row     = '0;
                            n_col     = '0;
                            n_bias_ph = 1'b1;
                            n_state   = S_STREAM;
                        end
                    end
                endcase
            end
            S_START_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_NEG;
                o_cmd.wr_axis = r_axis;
                n_axis        = r_axis + 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_EST_RD: begin
                o_cmd.rd.en   = 1'b1;
                o_cmd.rd.est  = 1'b1;
                o_cmd.rd.col  = r_axis;
                o_cmd.rd.addr = GYRO_BASE + SLOT_W'(r_axis);
                n_axis        = r_axis + 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_state = S_EST_WAIT;
                end
            end
            S_EST_WAIT: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_axis  = '0;
                    n_state = S_EST_WB;
                end
            end
            S_EST_WB: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_BIAS;
                o_cmd.wr_axis = r_axis;
                n_axis        = r_axis + 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_sens    = '0;
                    n_row     = '0;
                    n_col     = '0;
                    n_bias_ph = 1'b1;
                    n_state   = S_STREAM;
                end
            end
            S_STREAM: begin
                o_cmd.rd.en   = 1'b1;
                o_cmd.rd.bias = r_bias_ph;
                o_cmd.rd.sens = r_sens;
                o_cmd.rd.row  = r_row;
                o_cmd.rd.col  = r_col;
                o_cmd.rd.addr = stream_addr;
                // advance column, then bias phase or row, then sensor
                if (r_col == AXIS_LAST) begin
                    n_col = '0;
                    if (r_bias_ph) begin
                        n_bias_ph = 1'b0;
                    end else if (r_row == AXIS_LAST) begin
                        n_row     = '0;
                        n_bias_ph = 1'b1;
                        n_sens    = r_sens + 1'b1;
                        if (r_sens == AXIS_LAST) begin
                            n_drain = 1'b0;
                            n_state = S_DRAIN;
                        end
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_PUBLISH;
                end
            end
            S_PUBLISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_sens      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_bias_ph   <= 1'b0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_sens      <= n_sens;
            r_row       <= n_row;
            r_col       <= n_col;
            r_bias_ph   <= n_bias_ph;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    // Divider completion always leads into bias write-back
    a_div_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.div_busy) |=> (r_state == S_EST_WB))
        else $error("divider finished without bias write-back");

    // A result published into a free output register shows up as valid
    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUBLISH && out_free) |=> o_out_valid)
        else $error("published result not presented");

    // Reads stay inside the coefficient store
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd.en |-> (o_cmd.rd.addr < SLOT_W'(COEF_SLOTS)))
        else $error("coefficient read out of range");

    // Store port is never read and written in the same cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> !o_cmd.rd.en)
        else $error("coefficient store read and write collide");

endmodule

// ===== rtl/imu_bias_scale_compensation.sv =====
`timescale 1ns / 1ps
// IMU bias and scale-matrix compensation.
// Input channel (i_in_valid / o_in_stall) carries one item: a command plus
// nine raw axes and a coefficient slot/value. Command 0 compensates a sample
// and returns one result item on the output channel (o_out_valid /
// i_out_stall); start, stop and coefficient-write commands return nothing.
// One item is worked on at a time. For a sample, 36 coefficient reads go through
// the single store port, one per cycle, with a 2-stage read/multiply-accumulate
// pipe behind it; the next item is taken in the cycle after the result is loaded.
// While gyro bias estimation runs, the three gyro biases first pass through
// three parallel 17-step restoring dividers.
// A finished result sits in the output register; the block takes the next
// item meanwhile and holds a new result until that register is free.
// Reset (synchronous, active low) restores zero biases and identity scale
// matrices at once, stops estimation and clears the sample count.
module imu_bias_scale_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic signed [15:0] i_acc_x,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_acc_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic signed [15:0] i_mag_x,
    input  logic signed [15:0] i_mag_y,
    input  logic signed [15:0] i_mag_z,
    input  logic [5:0]  i_coef_index,
    input  logic signed [15:0] i_coef_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_acc_x_out,
    output logic signed [15:0] o_acc_y_out,
    output logic signed [15:0] o_acc_z_out,
    output logic signed [15:0] o_gyro_x_out,
    output logic signed [15:0] o_gyro_y_out,
    output logic signed [15:0] o_gyro_z_out,
    output logic signed [15:0] o_mag_x_out,
    output logic signed [15:0] o_mag_y_out,
    output logic signed [15:0] o_mag_z_out,
    output logic        o_estimating,
    output logic [15:0] o_samples_averaged
);
    import ibsc_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_sample    raw_in [SENSORS][AXES];
    t_sample    res [SENSORS][AXES];

    // Gather raw axes by sensor
    always_comb begin
        raw_in[0][0] = i_acc_x;
        raw_in[0][1] = i_acc_y;
        raw_in[0][2] = i_acc_z;
        raw_in[1][0] = i_gyro_x;
        raw_in[1][1] = i_gyro_y;
        raw_in[1][2] = i_gyro_z;
        raw_in[2][0] = i_mag_x;
        raw_in[2][1] = i_mag_y;
        raw_in[2][2] = i_mag_z;
    end

    ibsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    ibsc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .i_command          (i_command),
        .i_raw              (raw_in),
        .i_coef_index       (i_coef_index),
        .i_coef_value       (i_coef_value),
        .o_res              (res),
        .o_estimating       (o_estimating),
        .o_samples_averaged (o_samples_averaged)
    );

    // Spread results to axis ports
    assign o_acc_x_out  = res[0][0];
    assign o_acc_y_out  = res[0][1];
    assign o_acc_z_out  = res[0][2];
    assign o_gyro_x_out = res[1][0];
    assign o_gyro_y_out = res[1][1];
    assign o_gyro_z_out = res[1][2];
    assign o_mag_x_out  = res[2][0];
    assign o_mag_y_out  = res[2][1];
    assign o_mag_z_out  = res[2][2];

endmodule

// ===== tb/imu_bias_scale_compensation_test.sv =====
`timescale 1ns / 1ps

// One item on the input channel: command, nine raw axes, coefficient slot/value
typedef struct packed {
    logic [1:0]       command;
    logic [8:0][15:0] axis;      // acc x/y/z, gyro x/y/z, mag x/y/z
    logic [5:0]       coef_index;
    logic [15:0]      coef_value;
} t_imu_item;

// One item on the output channel
typedef struct packed {
    logic [8:0][15:0] axis;
    logic             estimating;
    logic [15:0]      averaged;
} t_imu_result;

class imu_comp_scoreboard;
    // Shadow of the block's calibration state
    logic signed [15:0] coef [ibsc_pkg::COEF_SLOTS];
    bit                 running;
    logic [15:0]        count;
    logic signed [15:0] last_gyro [ibsc_pkg::AXES];

    t_imu_result compensated_q [$];
    string       axis_names [9];
    int          errors;
    int          results_seen;
    int          coef_writes;
    int          est_starts;

    function new();
        axis_names = '{"acc_x", "acc_y", "acc_z", "gyro_x", "gyro_y", "gyro_z",
                       "mag_x", "mag_y", "mag_z"};
        for (int k = 0; k < ibsc_pkg::COEF_SLOTS; k++) begin
            coef[k] = '0;
        end
        for (int s = 0; s < ibsc_pkg::SENSORS; s++) begin
            for (int r = 0; r < ibsc_pkg::AXES; r++) begin
                coef[s * ibsc_pkg::SLOTS_PER_SENSOR + ibsc_pkg::AXES
                     + r * ibsc_pkg::AXES + r] = ibsc_pkg::COEF_ONE;
            end
        end
        running = 1'b0;
        count   = '0;
        for (int r = 0; r < ibsc_pkg::AXES; r++) begin
            last_gyro[r] = '0;
        end
    endfunction

    function logic signed [15:0] clamp_sample(longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Update the gyro bias estimate, then apply bias and scale matrix per sensor
    function t_imu_result compensate_sample(t_imu_item it);
        t_imu_result res;
        longint      raw [9];
        longint      sum [3];
        longint      acc;
        longint      bias;
        longint      quot;
        longint      divisor;
        int          base;
        for (int i = 0; i < 9; i++) begin
            raw[i] = longint'($signed(it.axis[i]));
        end
        for (int r = 0; r < ibsc_pkg::AXES; r++) begin
            last_gyro[r] = 16'(raw[ibsc_pkg::AXES * ibsc_pkg::GYRO_SENSOR + r]);
        end
        if (running) begin
            if (count != 16'hFFFF) begin
                count++;
            end
            divisor = longint'(count);
            base    = ibsc_pkg::GYRO_SENSOR * ibsc_pkg::SLOTS_PER_SENSOR;
            for (int r = 0; r < ibsc_pkg::AXES; r++) begin
                bias = longint'(coef[base + r]);
                quot = (bias + raw[ibsc_pkg::AXES * ibsc_pkg::GYRO_SENSOR + r]) / divisor;
                coef[base + r] = clamp_sample(bias - quot);
            end
        end
        for (int s = 0; s < ibsc_pkg::SENSORS; s++) begin
            base = s * ibsc_pkg::SLOTS_PER_SENSOR;
            for (int c = 0; c < ibsc_pkg::AXES; c++) begin
                sum[c] = raw[s * ibsc_pkg::AXES + c] + longint'(coef[base + c]);
            end
            for (int r = 0; r < ibsc_pkg::AXES; r++) begin
                acc = 0;
                for (int c = 0; c < ibsc_pkg::AXES; c++) begin
                    acc += longint'(coef[base + ibsc_pkg::AXES + r * ibsc_pkg::AXES + c])
                           * sum[c];
                end
                res.axis[s * ibsc_pkg::AXES + r] = clamp_sample(acc >>> ibsc_pkg::FRAC_BITS);
            end
        end
        res.estimating = running;
        res.averaged   = count;
        return res;
    endfunction

    // Apply one accepted item; return 0 when the block merely ignores it
    function bit note_item(t_imu_item it);
        int base;
        base = ibsc_pkg::GYRO_SENSOR * ibsc_pkg::SLOTS_PER_SENSOR;
        case (it.command)
            ibsc_pkg::CMD_SAMPLE: begin
                compensated_q.push_back(compensate_sample(it));
            end
            ibsc_pkg::CMD_START: begin
                est_starts++;
                count   = '0;
                running = 1'b1;
                for (int r = 0; r < ibsc_pkg::AXES; r++) begin
                    coef[base + r] = clamp_sample(-longint'(last_gyro[r]));
                end
            end
            ibsc_pkg::CMD_STOP: begin
                if (!running) begin
                    return 1'b0;
                end
                running = 1'b0;
            end
            default: begin
                if (it.coef_index >= ibsc_pkg::COEF_SLOTS) begin
                    return 1'b0;
                end
                coef_writes++;
                coef[it.coef_index] = it.coef_value;
            end
        endcase
        return 1'b1;
    endfunction

    task report_mismatch(string what, longint got, longint want);
        errors++;
        if (errors <= 40) begin
            $display("ERROR at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
        end
    endtask

    // Compare one output item against the oldest pending sample
    task check_result(t_imu_result got);
        t_imu_result want;
        results_seen++;
        if (compensated_q.size() == 0) begin
            report_mismatch("result with no sample pending", 1, 0);
            return;
        end
        want = compensated_q.pop_front();
        for (int i = 0; i < 9; i++) begin
            if (got.axis[i] !== want.axis[i]) begin
                report_mismatch(axis_names[i], longint'($signed(got.axis[i])),
                                longint'($signed(want.axis[i])));
            end
        end
        if (got.estimating !== want.estimating) begin
            report_mismatch("estimating", got.estimating, want.estimating);
        end
        if (got.averaged !== want.averaged) begin
            report_mismatch("samples_averaged", got.averaged, want.averaged);
        end
    endtask
endclass

module imu_bias_scale_compensation_test;

    localparam int TARGET_ITEMS = 1450;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int SENSOR_ACC   = 0;
    localparam int SENSOR_GYRO  = ibsc_pkg::GYRO_SENSOR;
    localparam int SENSOR_MAG   = 2;
    localparam int SCALE_FIRST  = ibsc_pkg::AXES;
    localparam int SLOT_TOP     = 63;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_command;
    logic signed [15:0] i_acc_x, i_acc_y, i_acc_z;
    logic signed [15:0] i_gyro_x, i_gyro_y, i_gyro_z;
    logic signed [15:0] i_mag_x, i_mag_y, i_mag_z;
    logic [5:0]         i_coef_index;
    logic signed [15:0] i_coef_value;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_acc_x_out, o_acc_y_out, o_acc_z_out;
    logic signed [15:0] o_gyro_x_out, o_gyro_y_out, o_gyro_z_out;
    logic signed [15:0] o_mag_x_out, o_mag_y_out, o_mag_z_out;
    logic               o_estimating;
    logic [15:0]        o_samples_averaged;

    imu_comp_scoreboard board;
    int                 useful_items;
    int                 burst_left;
    int                 stall_cycles;
    int                 calm_cycles;
    int                 quiet_cycles;

    imu_bias_scale_compensation dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_acc_x           (i_acc_x),
        .i_acc_y           (i_acc_y),
        .i_acc_z           (i_acc_z),
        .i_gyro_x          (i_gyro_x),
        .i_gyro_y          (i_gyro_y),
        .i_gyro_z          (i_gyro_z),
        .i_mag_x           (i_mag_x),
        .i_mag_y           (i_mag_y),
        .i_mag_z           (i_mag_z),
        .i_coef_index      (i_coef_index),
        .i_coef_value      (i_coef_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_acc_x_out       (o_acc_x_out),
        .o_acc_y_out       (o_acc_y_out),
        .o_acc_z_out       (o_acc_z_out),
        .o_gyro_x_out      (o_gyro_x_out),
        .o_gyro_y_out      (o_gyro_y_out),
        .o_gyro_z_out      (o_gyro_z_out),
        .o_mag_x_out       (o_mag_x_out),
        .o_mag_y_out       (o_mag_y_out),
        .o_mag_z_out       (o_mag_z_out),
        .o_estimating      (o_estimating),
        .o_samples_averaged(o_samples_averaged)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] spread_value(int spread);
        int v;
        v = int'($urandom_range(0, 2 * spread)) - spread;
        return 16'(v);
    endfunction

    function automatic logic [5:0] coef_slot(int sensor, int k);
        return 6'(sensor * ibsc_pkg::SLOTS_PER_SENSOR + k);
    endfunction

    function automatic t_imu_item junk_item();
        t_imu_item it;
        it.command = 2'($urandom_range(0, 3));
        for (int i = 0; i < 9; i++) begin
            it.axis[i] = 16'($urandom_range(0, 65535));
        end
        it.coef_index = 6'($urandom_range(0, SLOT_TOP));
        it.coef_value = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic t_imu_item command_item(logic [1:0] cmd);
        t_imu_item it;
        it = junk_item();
        it.command = cmd;
        return it;
    endfunction

    function automatic t_imu_item write_item(logic [5:0] slot, logic [15:0] value);
        t_imu_item it;
        it = command_item(ibsc_pkg::CMD_WRITE);
        it.coef_index = slot;
        it.coef_value = value;
        return it;
    endfunction

    function automatic t_imu_item uniform_sample(logic [15:0] value);
        t_imu_item it;
        it = command_item(ibsc_pkg::CMD_SAMPLE);
        for (int i = 0; i < 9; i++) begin
            it.axis[i] = value;
        end
        return it;
    endfunction

    // Mostly realistic magnitudes, some full range, a few rail values
    function automatic t_imu_item random_sample();
        t_imu_item it;
        int        kind;
        kind = $urandom_range(0, 9);
        it = command_item(ibsc_pkg::CMD_SAMPLE);
        for (int i = 0; i < 9; i++) begin
            if (kind < 6) begin
                it.axis[i] = spread_value(4000);
            end else if (kind < 9) begin
                it.axis[i] = 16'($urandom_range(0, 65535));
            end else begin
                it.axis[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
        end
        return it;
    endfunction

    // Plausible calibration value for slot k of a sensor
    function automatic logic [15:0] coef_guess(int k);
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        if (k < ibsc_pkg::AXES) begin
            return spread_value(3000);
        end
        if ((k - SCALE_FIRST) % (ibsc_pkg::AXES + 1) == 0) begin
            return ibsc_pkg::COEF_ONE + spread_value(2500);
        end
        return spread_value(1500);
    endfunction

    // Present one item, hold it until accepted, then maybe idle
    task automatic send_item(t_imu_item it);
        int gap;
        i_in_valid   <= 1'b1;
        i_command    <= it.command;
        i_acc_x      <= it.axis[0];
        i_acc_y      <= it.axis[1];
        i_acc_z      <= it.axis[2];
        i_gyro_x     <= it.axis[3];
        i_gyro_y     <= it.axis[4];
        i_gyro_z     <= it.axis[5];
        i_mag_x      <= it.axis[6];
        i_mag_y      <= it.axis[7];
        i_mag_z      <= it.axis[8];
        i_coef_index <= it.coef_index;
        i_coef_value <= it.coef_value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (board.note_item(it)) begin
            useful_items++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold the sender off until every pending sample has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.compensated_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        t_imu_item it;
        send_item(uniform_sample(16'h0000));
        send_item(uniform_sample(16'h7FFF));
        // leave the most negative gyro as the latest raw sample
        send_item(uniform_sample(16'h8000));
        send_item(command_item(ibsc_pkg::CMD_STOP));
        // negated most negative gyro must saturate the bias
        send_item(command_item(ibsc_pkg::CMD_START));
        send_item(uniform_sample(16'h8000));
        send_item(uniform_sample(16'h7FFF));
        // restart while running
        send_item(command_item(ibsc_pkg::CMD_START));
        it = random_sample();
        it.axis[3] = 16'd100;
        it.axis[4] = -16'sd100;
        it.axis[5] = 16'd5;
        send_item(it);
        send_item(command_item(ibsc_pkg::CMD_STOP));
        send_item(random_sample());
        // slots past the table are dropped
        send_item(write_item(6'(ibsc_pkg::COEF_SLOTS), 16'd1234));
        send_item(write_item(6'(SLOT_TOP), 16'hFFFF));
        // push the acc and mag paths to the rails
        send_item(write_item(coef_slot(SENSOR_ACC, 0), 16'h7FFF));
        send_item(write_item(coef_slot(SENSOR_ACC, SCALE_FIRST), 16'h7FFF));
        send_item(write_item(coef_slot(SENSOR_ACC, SCALE_FIRST + 1), 16'h8000));
        send_item(write_item(coef_slot(SENSOR_MAG, 2), 16'h8000));
        send_item(write_item(coef_slot(SENSOR_MAG, ibsc_pkg::SLOTS_PER_SENSOR - 1), 16'h8000));
        send_item(uniform_sample(16'h7FFF));
        send_item(uniform_sample(16'h8000));
        send_item(random_sample());
    endtask

    task automatic run_random();
        t_imu_item it;
        int        pick;
        int        n;
        int        s;
        int        k;
        int        next_pause;
        int        offs [3];
        next_pause = 400;
        while (useful_items < TARGET_ITEMS) begin
            if (useful_items >= next_pause) begin
                drain_results();
                next_pause += 400;
            end
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(10, 40);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // plain sample stream
                repeat ($urandom_range(5, 30)) send_item(random_sample());
            end else if (pick < 55) begin
                // calibrate part of one sensor
                s = $urandom_range(0, ibsc_pkg::SENSORS - 1);
                repeat ($urandom_range(1, 12)) begin
                    k = $urandom_range(0, ibsc_pkg::SLOTS_PER_SENSOR - 1);
                    send_item(write_item(coef_slot(s, k), coef_guess(k)));
                end
            end else if (pick < 80) begin
                // bias estimation around a steady gyro offset
                for (int a = 0; a < ibsc_pkg::AXES; a++) begin
                    offs[a] = ($urandom_range(0, 9) == 0) ? int'($signed(spread_value(32767)))
                                                          : int'($signed(spread_value(3000)));
                end
                send_item(command_item(ibsc_pkg::CMD_START));
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(3, 40);
                repeat (n) begin
                    it = random_sample();
                    for (int a = 0; a < ibsc_pkg::AXES; a++) begin
                        it.axis[ibsc_pkg::AXES * SENSOR_GYRO + a] =
                            16'(offs[a] + int'($signed(spread_value(60))));
                    end
                    send_item(it);
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_item(command_item(ibsc_pkg::CMD_STOP));
                end
            end else if (pick < 95) begin
                // arbitrary items, any command and any slot
                repeat ($urandom_range(1, 6)) send_item(junk_item());
            end else begin
                // restore zero bias and identity scale for one sensor
                s = $urandom_range(0, ibsc_pkg::SENSORS - 1);
                for (int j = 0; j < ibsc_pkg::SLOTS_PER_SENSOR; j++) begin
                    if (j >= SCALE_FIRST && (j - SCALE_FIRST) % (ibsc_pkg::AXES + 1) == 0) begin
                        send_item(write_item(coef_slot(s, j), ibsc_pkg::COEF_ONE));
                    end else begin
                        send_item(write_item(coef_slot(s, j), 16'h0000));
                    end
                end
            end
        end
    endtask

    // Output stall: random bursts with calm stretches in between
    always @(posedge i_clk) begin
        if (stall_cycles > 0) begin
            stall_cycles = stall_cycles - 1;
        end else if (calm_cycles > 0) begin
            calm_cycles = calm_cycles - 1;
        end else if ($urandom_range(0, 99) < 3) begin
            calm_cycles = $urandom_range(100, 600);
        end else if ($urandom_range(0, 3) == 0) begin
            stall_cycles = pick_gap();
        end
        i_out_stall <= (stall_cycles > 0);
    end

    // Check every accepted output item
    always @(posedge i_clk) begin
        t_imu_result got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall) begin
            got.axis[0]    = o_acc_x_out;
            got.axis[1]    = o_acc_y_out;
            got.axis[2]    = o_acc_z_out;
            got.axis[3]    = o_gyro_x_out;
            got.axis[4]    = o_gyro_y_out;
            got.axis[5]    = o_gyro_z_out;
            got.axis[6]    = o_mag_x_out;
            got.axis[7]    = o_mag_y_out;
            got.axis[8]    = o_mag_z_out;
            got.estimating = o_estimating;
            got.averaged   = o_samples_averaged;
            board.check_result(got);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0)
            || (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("imu_bias_scale_compensation_test failed");
            $finish;
        end
    end

    initial begin
        board        = new();
        useful_items = 0;
        burst_left   = 0;
        stall_cycles = 0;
        calm_cycles  = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = ibsc_pkg::CMD_SAMPLE;
        i_acc_x      = '0;
        i_acc_y      = '0;
        i_acc_z      = '0;
        i_gyro_x     = '0;
        i_gyro_y     = '0;
        i_gyro_z     = '0;
        i_mag_x      = '0;
        i_mag_y      = '0;
        i_mag_z      = '0;
        i_coef_index = '0;
        i_coef_value = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_results();
        run_random();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.compensated_q.size() != 0) begin
            board.report_mismatch("samples never answered", board.compensated_q.size(), 0);
        end
        $display("Covered %0d items: %0d compensated samples, %0d coefficient writes, %0d bias runs.",
                 useful_items, board.results_seen, board.coef_writes, board.est_starts);
        $display("Included rail values, saturating gyro bias, dropped slots and stalls on both sides.");
        if (board.errors == 0) begin
            $display("imu_bias_scale_compensation_test passed");
        end else begin
            $display("imu_bias_scale_compensation_test failed");
        end
        $finish;
    end

endmodule

// ===== imu_bias_scale_compensation.f =====
rtl/ibsc_pkg.sv
rtl/ibsc_div.sv
rtl/ibsc_dp.sv
rtl/ibsc_ctrl.sv
rtl/imu_bias_scale_compensation.sv
tb/imu_bias_scale_compensation_test.sv
